>>> rtl/sgd_momentum_update_macros.svh
// Assertion macros for the SGD momentum update block.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SGD_MOMENTUM_UPDATE_MACROS_SVH
`define SGD_MOMENTUM_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sgdm_pkg.sv
// Shared types and constants for the SGD momentum update block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package sgdm_pkg;

  localparam int DATA_W    = 32;   // Q8.24 element width
  localparam int FACT_W    = 18;   // Q2.16 factor width
  localparam int FRAC_W    = 16;   // fraction bits of a factor
  localparam int CFG_IDX_W = 2;

  typedef logic signed [DATA_W-1:0] q824_t;
  typedef logic [FACT_W-1:0]        fact_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_MOMENTUM      = 2'd1,
    CFG_DECAY         = 2'd2,
    CFG_NESTEROV      = 2'd3
  } cfg_idx_t;

  localparam fact_t LR_RESET = 18'd655;

  // Saturation bounds, on the 40-bit working width and on the result width.
  localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;
  localparam q824_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q824_t Q_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

>>> rtl/sgdm_in_if.sv
// Input channel: parameter, gradient and velocity element with valid/ready.
// Depends on sgdm_pkg.
`default_nettype none

interface sgdm_in_if import sgdm_pkg::*; ();
  logic  valid;
  logic  ready;
  q824_t param_value;
  q824_t grad_value;
  q824_t velocity_value;
  logic  last_in;

  modport source (output valid, param_value, grad_value, velocity_value, last_in,
                  input ready);
  modport sink   (input valid, param_value, grad_value, velocity_value, last_in,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sgdm_out_if.sv
// Result channel: updated parameter and velocity element with valid/ready.
// Depends on sgdm_pkg.
`default_nettype none

interface sgdm_out_if import sgdm_pkg::*; ();
  logic  valid;
  logic  ready;
  q824_t new_param;
  q824_t vel_update;
  logic  last_out;
  logic  saturated;

  modport source (output valid, new_param, vel_update, last_out, saturated,
                  input ready);
  modport sink   (input valid, new_param, vel_update, last_out, saturated,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sgd_momentum_update.sv
// SGD with momentum / Nesterov element update, six-stage pipeline.
// Depends on sgdm_pkg, sgdm_in_if, sgdm_out_if and sgd_momentum_update_macros.svh.
//
// Usage:
//  - in_ch carries one element per item: param, grad, velocity (Q8.24) and last_in.
//  - out_ch returns one item per input item, in order: new_param, vel_update,
//    last_out (copy of last_in) and saturated (either result was clipped).
//  - cfg_we/cfg_index/cfg_data write learning rate, momentum, weight decay and
//    Nesterov enable (index order); unused data bits are dropped. Write only
//    when the pipeline is empty.
//  - Throughput: one item per cycle unless stalled. The path is six register
//    stages: two factor multiplies, add/clip of velocity, Nesterov multiply,
//    look-ahead add, learning-rate multiply, then parameter subtract and clip.
//  - Each stage holds while its successor is full and stalled; empty stages
//    keep filling, so in_ch stays ready while bubbles remain even when the
//    receiver stalls. Nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) empties the pipeline and restores the
//    registers: learning rate 655, momentum 0, decay 0, Nesterov off.
`default_nettype none
`include "sgd_momentum_update_macros.svh"

module sgd_momentum_update import sgdm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FACT_W-1:0]    cfg_data,
  sgdm_in_if.sink                   in_ch,
  sgdm_out_if.source                out_ch
);

  // ---------------------------------------------------------------- config
  fact_t lr_r, mom_r, decay_r;
  logic  nest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RESET;
      mom_r   <= '0;
      decay_r <= '0;
      nest_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEARNING_RATE: lr_r    <= cfg_data;
        CFG_MOMENTUM:      mom_r   <= cfg_data;
        CFG_DECAY:         decay_r <= cfg_data;
        CFG_NESTEROV:      nest_r  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  logic mom_on;
  assign mom_on = (mom_r != '0);

  // Clip a 40-bit value to Q8.24; MSB of the result is the clip flag.
  function automatic logic [DATA_W:0] sat32(input logic signed [39:0] x);
    logic [DATA_W:0] res;
    if (x > SAT_HI)
      res = {1'b1, Q_MAX};
    else if (x < SAT_LO)
      res = {1'b1, Q_MIN};
    else
      res = {1'b0, x[DATA_W-1:0]};
    return res;
  endfunction

  // ------------------------------------------------------ pipeline control
  // rdy[k]: stage k may load this cycle (empty, or its item moves on).
  logic [6:1] v_r;
  logic [6:1] rdy;

  assign rdy[6] = !v_r[6] || out_ch.ready;
  assign rdy[5] = !v_r[5] || rdy[6];
  assign rdy[4] = !v_r[4] || rdy[5];
  assign rdy[3] = !v_r[3] || rdy[4];
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];

  assign in_ch.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_ch.valid;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
      if (rdy[5]) v_r[5] <= v_r[4];
      if (rdy[6]) v_r[6] <= v_r[5];
    end
  end

  // ------------------------------------------ stage 1: decay, momentum*vin
  logic signed [50:0] dp_s1_nxt, mv_s1_nxt;
  logic signed [50:0] dp_s1_r, mv_s1_r;
  q824_t p_s1_r, gr_s1_r, vin_s1_r;
  logic  last_s1_r;

  assign dp_s1_nxt = in_ch.param_value * $signed({1'b0, decay_r});
  assign mv_s1_nxt = in_ch.velocity_value * $signed({1'b0, mom_r});

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dp_s1_r   <= dp_s1_nxt;
      mv_s1_r   <= mv_s1_nxt;
      p_s1_r    <= in_ch.param_value;
      gr_s1_r   <= in_ch.grad_value;
      vin_s1_r  <= in_ch.velocity_value;
      last_s1_r <= in_ch.last_in;
    end
  end

  // ------------------------- stage 2: effective gradient, new velocity
  // |g| < 2^31 + 2^33 fits 35 bits; momentum*v + g fits 37 bits.
  logic signed [34:0] g_s2_nxt;
  logic signed [36:0] vsum_s2;
  logic [DATA_W:0]    vclip_s2;
  q824_t              vnew_s2_nxt;
  logic               satv_s2_nxt;

  logic signed [34:0] g_s2_r;
  q824_t              vnew_s2_r, p_s2_r;
  logic               satv_s2_r, last_s2_r;

  assign g_s2_nxt = $signed({{3{gr_s1_r[31]}}, gr_s1_r}) + $signed(dp_s1_r[50:16]);
  assign vsum_s2  = $signed({{2{mv_s1_r[50]}}, mv_s1_r[50:16]})
                  + $signed({{2{g_s2_nxt[34]}}, g_s2_nxt});
  assign vclip_s2 = sat32($signed({{3{vsum_s2[36]}}, vsum_s2}));

  always_comb begin
    if (mom_on) begin
      vnew_s2_nxt = vclip_s2[DATA_W-1:0];
      satv_s2_nxt = vclip_s2[DATA_W];
    end else begin
      // plain SGD: velocity passes through untouched
      vnew_s2_nxt = vin_s1_r;
      satv_s2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      g_s2_r    <= g_s2_nxt;
      vnew_s2_r <= vnew_s2_nxt;
      satv_s2_r <= satv_s2_nxt;
      p_s2_r    <= p_s1_r;
      last_s2_r <= last_s1_r;
    end
  end

  // ---------------------------------- stage 3: momentum * new velocity
  logic signed [50:0] mvn_s3_nxt, mvn_s3_r;
  logic signed [34:0] g_s3_r;
  q824_t              vnew_s3_r, p_s3_r;
  logic               satv_s3_r, last_s3_r;

  assign mvn_s3_nxt = vnew_s2_r * $signed({1'b0, mom_r});

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      mvn_s3_r  <= mvn_s3_nxt;
      g_s3_r    <= g_s2_r;
      vnew_s3_r <= vnew_s2_r;
      satv_s3_r <= satv_s2_r;
      p_s3_r    <= p_s2_r;
      last_s3_r <= last_s2_r;
    end
  end

  // ------------------------------------ stage 4: pick the step operand
  logic signed [35:0] look_s4;
  logic signed [35:0] x_s4_nxt, x_s4_r;
  q824_t              vnew_s4_r, p_s4_r;
  logic               satv_s4_r, last_s4_r;

  assign look_s4 = $signed({mvn_s3_r[50], mvn_s3_r[50:16]})
                 + $signed({g_s3_r[34], g_s3_r});

  always_comb begin
    if (!mom_on)
      x_s4_nxt = $signed({g_s3_r[34], g_s3_r});
    else if (nest_r)
      x_s4_nxt = look_s4;
    else
      x_s4_nxt = $signed({{4{vnew_s3_r[31]}}, vnew_s3_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      x_s4_r    <= x_s4_nxt;
      vnew_s4_r <= vnew_s3_r;
      satv_s4_r <= satv_s3_r;
      p_s4_r    <= p_s3_r;
      last_s4_r <= last_s3_r;
    end
  end

  // ---------------------------------------- stage 5: learning-rate step
  logic signed [54:0] prod_s5_nxt, prod_s5_r;
  q824_t              vnew_s5_r, p_s5_r;
  logic               satv_s5_r, last_s5_r;

  assign prod_s5_nxt = x_s4_r * $signed({1'b0, lr_r});

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      prod_s5_r <= prod_s5_nxt;
      vnew_s5_r <= vnew_s4_r;
      satv_s5_r <= satv_s4_r;
      p_s5_r    <= p_s4_r;
      last_s5_r <= last_s4_r;
    end
  end

  // ------------------------- stage 6: parameter update, output register
  logic signed [38:0] step_s6;
  logic signed [39:0] diff_s6;
  logic [DATA_W:0]    pclip_s6;

  q824_t pnew_s6_r, vnew_s6_r;
  logic  sat_s6_r, last_s6_r;

  assign step_s6  = $signed(prod_s5_r[54:16]);
  assign diff_s6  = $signed({{8{p_s5_r[31]}}, p_s5_r}) - $signed({step_s6[38], step_s6});
  assign pclip_s6 = sat32(diff_s6);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pnew_s6_r <= pclip_s6[DATA_W-1:0];
      vnew_s6_r <= vnew_s5_r;
      sat_s6_r  <= satv_s5_r | pclip_s6[DATA_W];
      last_s6_r <= last_s5_r;
    end
  end

  assign out_ch.valid      = v_r[6];
  assign out_ch.new_param  = pnew_s6_r;
  assign out_ch.vel_update = vnew_s6_r;
  assign out_ch.last_out   = last_s6_r;
  assign out_ch.saturated  = sat_s6_r;

  // ------------------------------------------------------------ checks
  // A ready receiver frees every stage, so the input must be open.
  `SGDM_ASSERT_NOW(a_ready_chain, clk, rst_n, out_ch.ready, in_ch.ready, "in_ch stalled while out_ch ready")
  // A result only appears after an item sat in stage 5.
  `SGDM_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_ch.valid), $past(v_r[5]), "result without stage 5 item")
  // The clip flag implies some result sits at a rail.
  `SGDM_ASSERT_NOW(a_sat_rail, clk, rst_n, out_ch.valid && out_ch.saturated, (out_ch.new_param == Q_MAX) || (out_ch.new_param == Q_MIN) || (mom_on && ((out_ch.vel_update == Q_MAX) || (out_ch.vel_update == Q_MIN))), "saturated flag without clipped result")

endmodule

`default_nettype wire
